### src/rqps_pkg.sv
// Package for the ready queue policy scheduler: sizes, entry type, command,
// policy and status codes, and the control word sent to each queue cell.
// No dependencies.
`default_nettype none

package rqps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 8;
   localparam int SIZE_W      = 16;
   localparam int CMD_W       = 2;
   localparam int POLICY_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;

   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(QUEUE_DEPTH);

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [POLICY_W-1:0] POL_KEEP     = 2'd0;
   localparam logic [POLICY_W-1:0] POL_ROUND    = 2'd1;
   localparam logic [POLICY_W-1:0] POL_SMALLEST = 2'd2;
   localparam logic [POLICY_W-1:0] POL_BIGGEST  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LEFT  = 2'd2,
      CELL_FROM_RIGHT = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   ext;
   } cell_ctl_type;

endpackage

`default_nettype wire

### src/rqps_if.sv
// Valid/ready channel interfaces for the scheduler's command and result words.
// Depends on rqps_pkg.
`default_nettype none

interface rqps_req_if;
   logic                             valid;
   logic                             ready;
   logic [rqps_pkg::CMD_W-1:0]       command;
   logic [rqps_pkg::ID_W-1:0]        process_id;
   logic [rqps_pkg::SIZE_W-1:0]      job_size;

   modport source (output valid, command, process_id, job_size, input ready);
   modport sink   (input valid, command, process_id, job_size, output ready);
endinterface

interface rqps_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             head_valid;
   logic [rqps_pkg::ID_W-1:0]        head_id;
   logic [rqps_pkg::SIZE_W-1:0]      head_size;
   logic [rqps_pkg::COUNT_W-1:0]     entry_count;
   logic [rqps_pkg::STATUS_W-1:0]    status;

   modport source (output valid, head_valid, head_id, head_size, entry_count, status,
                   input ready);
   modport sink   (input valid, head_valid, head_id, head_size, entry_count, status,
                   output ready);
endinterface

`default_nettype wire

### src/rqps_cell.sv
// One slot of the ready queue: holds an entry and takes a new one from its
// left or right neighbor or from the shared load bus. Depends on rqps_pkg.
`default_nettype none

module rqps_cell (
   input  wire logic                clock,
   input  wire rqps_pkg::cell_ctl_type ctl,
   input  wire rqps_pkg::entry_type left_entry,
   input  wire rqps_pkg::entry_type right_entry,
   output rqps_pkg::entry_type      entry
);

   rqps_pkg::entry_type entry_ff;
   rqps_pkg::entry_type entry_in;

   always_comb begin
      unique case (ctl.op)
         rqps_pkg::CELL_HOLD:       entry_in = entry_ff;
         rqps_pkg::CELL_LOAD:       entry_in = ctl.ext;
         rqps_pkg::CELL_FROM_LEFT:  entry_in = left_entry;
         rqps_pkg::CELL_FROM_RIGHT: entry_in = right_entry;
         default:                   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

### src/ready_queue_policy_scheduler.sv
// Top level of the ready queue policy scheduler: control sequencer, row of
// queue cells, policy register and result register. Depends on rqps_pkg,
// rqps_if and rqps_cell.
//
// Usage:
//   req_chan carries command words (append, scheduling event, remove by id);
//   rsp_chan returns one result word per command: front entry, entry count
//   and status. The policy register is written through csr_wr_en/csr_wr_data;
//   write it only while the block is idle (the block does not enforce this).
//   A word is accepted only while the sequencer is idle, one at a time.
//   Append, remove, round robin and keep-order events pass from the execute
//   state to the report state, where the result is loaded into the output
//   register before the next word is accepted. A smallest/biggest job event
//   on two or more entries scans the cells one per cycle in the scan state,
//   then moves the chosen entry to the front in the move state before report.
//   A result waits in the output register while rsp_chan is stalled; the
//   next word may be accepted meanwhile, but its result holds the sequencer
//   until the output register is free.
//   Reset empties the queue and sets the policy to keep order; cell
//   contents are not cleared. No word is accepted while reset is high.
`default_nettype none

module ready_queue_policy_scheduler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rqps_req_if.sink                             req_chan,
   rqps_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [rqps_pkg::POLICY_W-1:0]   csr_wr_data
);

   localparam int D     = rqps_pkg::QUEUE_DEPTH;
   localparam int IDX_W = rqps_pkg::IDX_W;
   localparam int LEN_W = rqps_pkg::LEN_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_MOVE   = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [rqps_pkg::POLICY_W-1:0]    policy_ff;
   logic [rqps_pkg::CMD_W-1:0]       cmd_ff;
   rqps_pkg::entry_type              new_ff;
   logic [LEN_W-1:0]                 len_ff, len_in;
   logic [rqps_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [IDX_W-1:0]                 k_ff, k_in;
   logic [IDX_W-1:0]                 best_idx_ff, best_idx_in;
   rqps_pkg::entry_type              best_ff, best_in;

   logic                             rsp_valid_ff;
   logic                             rsp_head_valid_ff;
   rqps_pkg::entry_type              rsp_head_ff;
   logic [rqps_pkg::COUNT_W-1:0]     rsp_count_ff;
   logic [rqps_pkg::STATUS_W-1:0]    rsp_status_ff;

   rqps_pkg::entry_type              cell_q [D];
   rqps_pkg::entry_type              ext_entry;
   rqps_pkg::entry_type              cand;

   logic [D-1:0]                     match;
   logic [D-1:0]                     first_oh;
   logic                             found;
   logic [LEN_W-1:0]                 len_m1;
   logic                             accept;
   logic                             out_free;
   logic                             exec;
   logic                             do_append, do_rotate, do_remove, do_move;
   logic                             size_pol;
   logic                             better;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && !reset;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign exec     = (state_ff == ST_EXEC);
   assign len_m1   = len_ff - LEN_W'(1);
   assign size_pol = (policy_ff == rqps_pkg::POL_SMALLEST) ||
                     (policy_ff == rqps_pkg::POL_BIGGEST);

   // id compare in every occupied cell; lowest match wins
   always_comb begin
      for (int i = 0; i < D; i++) begin
         match[i] = (LEN_W'(i) < len_ff) && (cell_q[i].id == new_ff.id);
      end
   end
   assign first_oh = match & (~match + D'(1));
   assign found    = |match;

   assign do_append = exec && (cmd_ff == rqps_pkg::CMD_APPEND) && (len_ff < rqps_pkg::FULL_LEN);
   assign do_rotate = exec && (cmd_ff == rqps_pkg::CMD_SCHED) &&
                      (policy_ff == rqps_pkg::POL_ROUND) && (len_ff >= LEN_W'(2));
   assign do_remove = exec && (cmd_ff == rqps_pkg::CMD_REMOVE) && found;
   assign do_move   = (state_ff == ST_MOVE) && (best_idx_ff != '0);

   always_comb begin
      if (do_append) begin
         ext_entry = new_ff;
      end else if (do_rotate) begin
         ext_entry = cell_q[0];
      end else begin
         ext_entry = best_ff;
      end
   end

   for (genvar i = 0; i < D; i++) begin : g_cell
      localparam logic [LEN_W-1:0] POS  = LEN_W'(i);
      localparam logic [IDX_W-1:0] IPOS = IDX_W'(i);
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == D - 1) ? i : i + 1;

      rqps_pkg::cell_ctl_type ctl;
      logic                   shift_on;

      assign shift_on = |first_oh[i:0];

      always_comb begin
         ctl.ext = ext_entry;
         if (do_append && (POS == len_ff)) begin
            ctl.op = rqps_pkg::CELL_LOAD;
         end else if (do_rotate && (POS == len_m1)) begin
            ctl.op = rqps_pkg::CELL_LOAD;
         end else if ((do_rotate || (do_remove && shift_on)) && (POS < len_m1)) begin
            ctl.op = rqps_pkg::CELL_FROM_RIGHT;
         end else if (do_move && (i == 0)) begin
            ctl.op = rqps_pkg::CELL_LOAD;
         end else if (do_move && (i != 0) && (IPOS <= best_idx_ff)) begin
            ctl.op = rqps_pkg::CELL_FROM_LEFT;
         end else begin
            ctl.op = rqps_pkg::CELL_HOLD;
         end
      end

      rqps_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_entry  (cell_q[LEFT]),
         .right_entry (cell_q[RIGHT]),
         .entry       (cell_q[i])
      );
   end

   // scan compare: strict, so the first extreme entry is kept on ties
   assign cand   = cell_q[k_ff];
   assign better = (policy_ff == rqps_pkg::POL_SMALLEST) ? (cand.size < best_ff.size)
                                                         : (cand.size > best_ff.size);

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      status_in   = status_ff;
      k_in        = k_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = rqps_pkg::STAT_OK;
            state_in  = ST_REPORT;
            unique case (cmd_ff)
               rqps_pkg::CMD_APPEND: begin
                  if (do_append) begin
                     len_in = len_ff + LEN_W'(1);
                  end else begin
                     status_in = rqps_pkg::STAT_FULL;
                  end
               end
               rqps_pkg::CMD_SCHED: begin
                  if (size_pol && (len_ff >= LEN_W'(2))) begin
                     best_idx_in = '0;
                     best_in     = cell_q[0];
                     k_in        = IDX_W'(1);
                     state_in    = ST_SCAN;
                  end
               end
               rqps_pkg::CMD_REMOVE: begin
                  if (found) begin
                     len_in = len_m1;
                  end else begin
                     status_in = rqps_pkg::STAT_NOT_FOUND;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (better) begin
               best_idx_in = k_ff;
               best_in     = cand;
            end
            k_in = k_ff + IDX_W'(1);
            if (LEN_W'(k_ff) == len_m1) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_ff    <= '0;
         policy_ff <= rqps_pkg::POL_KEEP;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff         <= req_chan.command;
         new_ff.id      <= req_chan.process_id;
         new_ff.size    <= req_chan.job_size;
      end
      status_ff   <= status_in;
      k_ff        <= k_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_REPORT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_REPORT) && out_free) begin
         rsp_head_valid_ff <= (len_ff != '0);
         rsp_head_ff       <= (len_ff != '0) ? cell_q[0] : '0;
         rsp_count_ff      <= rqps_pkg::COUNT_W'(len_ff);
         rsp_status_ff     <= status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.head_valid  = rsp_head_valid_ff;
   assign rsp_chan.head_id     = rsp_head_ff.id;
   assign rsp_chan.head_size   = rsp_head_ff.size;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.status      = rsp_status_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= rqps_pkg::FULL_LEN)
      else $error("queue length beyond depth");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && cmd_ff == rqps_pkg::CMD_APPEND &&
       len_ff < rqps_pkg::FULL_LEN) |=> (len_ff == $past(len_ff) + LEN_W'(1)))
      else $error("append did not grow the queue");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (LEN_W'(k_ff) < len_ff && size_pol))
      else $error("scan index outside the queue");

   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_head_valid_ff == (rsp_count_ff != '0) || len_ff > LEN_W'(31)))
      else $error("head flag disagrees with entry count");

endmodule

`default_nettype wire

### tb/sv/ready_queue_policy_scheduler_test.sv
// Testbench for the ready queue policy scheduler: command words with random
// pacing and result back-pressure, checked against an in-bench queue predictor.
// Depends on rqps_pkg, rqps_if and the ready_queue_policy_scheduler RTL.
`timescale 1ns / 100ps

module ready_queue_policy_scheduler_test;
   import rqps_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
   localparam int               PHASES        = 11;
   localparam int               PHASE_WORDS   = 150;
   localparam int               IDLE_LIMIT    = 3000;
   localparam int               HOLD_CYCLES   = 400;
   localparam int               HOLD_AFTER    = 200;

   typedef struct packed {
      logic                head_valid;
      logic [ID_W-1:0]     head_id;
      logic [SIZE_W-1:0]   head_size;
      logic [COUNT_W-1:0]  entry_count;
      logic [STATUS_W-1:0] status;
   } result_word_type;

   class sched_scoreboard;
      entry_type             slots[QUEUE_DEPTH];
      int                    length;
      logic [POLICY_W-1:0]   policy;
      result_word_type       pending_results[$];
      int                    mismatches;

      function new();
         length     = 0;
         policy     = POL_KEEP;
         mismatches = 0;
      endfunction

      function void set_policy(logic [POLICY_W-1:0] p);
         policy = p;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // first entry holding the extreme size wins; it moves to the front
      function void promote_extreme(bit smallest);
         int        best;
         int        k;
         entry_type held;
         best = 0;
         for (k = 1; k < length; k++) begin
            if (smallest ? (slots[k].size < slots[best].size)
                         : (slots[k].size > slots[best].size))
               best = k;
         end
         if (best != 0) begin
            held = slots[best];
            for (k = best; k > 0; k--) slots[k] = slots[k-1];
            slots[0] = held;
         end
      endfunction

      // predict the queue update and the result word for one accepted command
      function void apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                  logic [SIZE_W-1:0] size);
         result_word_type     r;
         logic [STATUS_W-1:0] status;
         entry_type           held;
         int                  k;
         int                  m;
         status = STAT_OK;
         case (cmd)
            CMD_APPEND: begin
               if (length >= QUEUE_DEPTH) begin
                  status = STAT_FULL;
               end else begin
                  slots[length].id   = id;
                  slots[length].size = size;
                  length++;
               end
            end
            CMD_SCHED: begin
               if (length > 0) begin
                  case (policy)
                     POL_ROUND: begin
                        if (length > 1) begin
                           held = slots[0];
                           for (k = 0; k + 1 < length; k++) slots[k] = slots[k+1];
                           slots[length-1] = held;
                        end
                     end
                     POL_SMALLEST: promote_extreme(1'b1);
                     POL_BIGGEST:  promote_extreme(1'b0);
                     default: ;
                  endcase
               end
            end
            CMD_REMOVE: begin
               status = STAT_NOT_FOUND;
               for (k = 0; k < length && status == STAT_NOT_FOUND; k++) begin
                  if (slots[k].id == id) begin
                     for (m = k; m + 1 < length; m++) slots[m] = slots[m+1];
                     length--;
                     status = STAT_OK;
                  end
               end
            end
            default: ;
         endcase
         r.head_valid  = (length > 0);
         r.head_id     = (length > 0) ? slots[0].id : '0;
         r.head_size   = (length > 0) ? slots[0].size : '0;
         r.entry_count = COUNT_W'(length);
         r.status      = status;
         pending_results.push_back(r);
      endfunction

      task report(string what);
         if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(result_word_type got);
         result_word_type want;
         if (pending_results.size() == 0) begin
            report("result word with no command outstanding");
            return;
         end
         want = pending_results.pop_front();
         if (got.head_valid !== want.head_valid)
            report($sformatf("head_valid got %0b want %0b", got.head_valid, want.head_valid));
         if (got.head_id !== want.head_id)
            report($sformatf("head_id got %0h want %0h", got.head_id, want.head_id));
         if (got.head_size !== want.head_size)
            report($sformatf("head_size got %0h want %0h", got.head_size, want.head_size));
         if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count got %0d want %0d", got.entry_count,
                             want.entry_count));
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [POLICY_W-1:0] csr_wr_data;

   rqps_req_if req_chan ();
   rqps_rsp_if rsp_chan ();

   sched_scoreboard board = new();

   int burst_left;
   int results_seen;
   int idle_cycles;

   ready_queue_policy_scheduler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // offer one command word; the sender works in bursts with gaps between them
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                            input logic [SIZE_W-1:0] size);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.process_id <= id;
      req_chan.job_size   <= size;
      do @(posedge clock); while (!req_chan.ready);
      board.apply_command(cmd, id, size);
      burst_left--;
      if (burst_left == 0) req_chan.valid <= 1'b0;
   endtask

   task automatic end_burst();
      if (burst_left != 0) begin
         req_chan.valid <= 1'b0;
         burst_left = 0;
      end
   endtask

   // policy writes only once every outstanding result has drained
   task automatic write_policy(input logic [POLICY_W-1:0] p);
      end_burst();
      while (board.pending() != 0) @(posedge clock);
      csr_wr_data <= p;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_policy(p);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         board.check_result({rsp_chan.head_valid, rsp_chan.head_id, rsp_chan.head_size,
                             rsp_chan.entry_count, rsp_chan.status});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: stretches of steady, random, periodic or heavy stalling, plus one
   // long hold-off so the block backs up into the command channel
   initial begin
      int mode;
      int run;
      int k;
      bit held_off;
      held_off       = 1'b0;
      rsp_chan.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && results_seen >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         run  = $urandom_range(20, 120);
         for (k = 0; k < run; k++) begin
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               2:       rsp_chan.ready <= (k % 4 != 3);
               default: rsp_chan.ready <= ($urandom_range(0, 9) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [CMD_W-1:0]    cmd;
      logic [ID_W-1:0]     id;
      logic [SIZE_W-1:0]   size;
      logic [POLICY_W-1:0] pol;
      int                  target;
      int                  r;
      int                  phase;
      int                  n;
      int                  k;

      clock               = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = POL_KEEP;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_APPEND;
      req_chan.process_id = '0;
      req_chan.job_size   = '0;
      burst_left          = 0;
      results_seen        = 0;
      idle_cycles         = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty queue: schedule, missing id, unused code
      send_word(CMD_SCHED, 8'h00, 16'h0000);
      send_word(CMD_REMOVE, 8'h00, 16'h0000);
      send_word(CMD_UNUSED, 8'hFF, 16'hFFFF);

      // single entry under round robin stays put
      write_policy(POL_ROUND);
      send_word(CMD_APPEND, 8'hFF, 16'hFFFF);
      send_word(CMD_SCHED, 8'h00, 16'h0000);

      // fill with size ties and a duplicate id, then one refused append
      send_word(CMD_APPEND, 8'h00, 16'h0000);
      for (k = 1; k < QUEUE_DEPTH - 1; k++) begin
         id   = (k == 12) ? 8'hFF : ID_W'(k * 17);
         size = (k == 5 || k == 9) ? 16'h0000 : (k == 7) ? 16'hFFFF : SIZE_W'(k * 1000);
         send_word(CMD_APPEND, id, size);
      end
      send_word(CMD_APPEND, 8'hAA, 16'h1234);
      send_word(CMD_SCHED, 8'h00, 16'h0000);

      write_policy(POL_SMALLEST);
      send_word(CMD_SCHED, 8'h00, 16'h0000);
      write_policy(POL_BIGGEST);
      send_word(CMD_SCHED, 8'h00, 16'h0000);
      // duplicate id: only the first one goes
      send_word(CMD_REMOVE, 8'hFF, 16'h0000);
      send_word(CMD_REMOVE, 8'hAB, 16'h0000);

      // random phases, each under its own policy; target length wanders so the
      // queue visits empty, partial and full
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       pol = POL_SMALLEST;
            1:       pol = POL_BIGGEST;
            2:       pol = POL_ROUND;
            3:       pol = POL_KEEP;
            default: pol = POLICY_W'($urandom_range(0, 3));
         endcase
         write_policy(pol);
         target = $urandom_range(0, QUEUE_DEPTH + 1);
         for (n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 39) == 0) target = $urandom_range(0, QUEUE_DEPTH + 1);
            r = $urandom_range(0, 99);
            if (r < 2)
               cmd = CMD_UNUSED;
            else if (r < 30)
               cmd = CMD_SCHED;
            else if (board.length < target ? r < 80 : r < 45)
               cmd = CMD_APPEND;
            else
               cmd = CMD_REMOVE;

            case ($urandom_range(0, 9))
               0, 1, 2, 3: id = ID_W'($urandom_range(0, 7));
               4:          id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default:    id = ID_W'($urandom);
            endcase
            if (cmd == CMD_REMOVE && board.length > 0 && $urandom_range(0, 3) != 0)
               id = board.slots[$urandom_range(0, board.length - 1)].id;

            case ($urandom_range(0, 3))
               0:       size = SIZE_W'($urandom_range(0, 3));
               1:       size = $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFE;
               default: size = SIZE_W'($urandom);
            endcase
            send_word(cmd, id, size);
         end
      end

      end_burst();
      while (board.pending() != 0) @(posedge clock);
      repeat (QUEUE_DEPTH + 4) @(posedge clock);
      if (board.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
